@@ rtl/depth_tested_pixel_blend_macros.svh @@
// Assertion macros for the depth tested pixel blend block.
// Used by the top level only; no other dependencies.
`ifndef DEPTH_TESTED_PIXEL_BLEND_MACROS_SVH
`define DEPTH_TESTED_PIXEL_BLEND_MACROS_SVH

// same-cycle implication
`define DTPB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtpb: same-cycle check failed");

// next-cycle implication
`define DTPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtpb: next-cycle check failed");

`endif

@@ rtl/dtpb_pkg.sv @@
// Shared types and constants for the depth tested pixel blend block.
// No dependencies.
`timescale 1ns / 1ps

package dtpb_pkg;

   localparam int MAX_WIDTH      = 512;
   localparam int MAX_HEIGHT     = 512;
   localparam int DEPTH_BITS     = 24;
   localparam int PIX_DEPTH_BITS = 24;
   localparam int COORD_BITS     = 11;
   localparam int CHAN_BITS      = 8;
   localparam int CFG_BITS       = 10;
   localparam int CFG_RESET      = 512;
   localparam int CSR_INDEX_BITS = 1;
   localparam int OP_BITS        = 2;
   localparam int STATUS_BITS    = 2;

   localparam int STORE_SIZE  = MAX_WIDTH * MAX_HEIGHT;
   localparam int INDEX_BITS  = $clog2(STORE_SIZE);
   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int Y_BITS      = $clog2(MAX_HEIGHT);
   localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);

   typedef enum logic [OP_BITS-1:0] {
      OP_REPLACE = 2'd0,
      OP_BLEND   = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OUTSIDE  = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_UPDATED  = 2'd2,
      STATUS_CLEARED  = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_type;

   typedef struct packed {
      logic load_item;
      logic calc_index;
      logic mem_read;
      logic multiply;
      logic mix;
      logic mem_write;
      logic sweep;
      logic sweep_zero;
      logic set_outside;
      logic set_clear;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               in_frame;
      logic               sweep_last;
   } stat_type;

endpackage

@@ rtl/dtpb_ctrl.sv @@
// Controller state machine for the depth tested pixel blend block.
// Depends on dtpb_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps

module dtpb_ctrl import dtpb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [8:0] {
      S_BOOT  = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_ADDR  = 9'b000000100,
      S_READ  = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_MIX   = 9'b000100000,
      S_WRITE = 9'b001000000,
      S_CLEAR = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_BOOT: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_zero = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.calc_index = 1'b1;
            if (stat.op == OP_CLEAR) begin
               state_in = S_CLEAR;
            end else if ((stat.op == OP_REPLACE || stat.op == OP_BLEND) && stat.in_frame) begin
               state_in = S_READ;
            end else begin
               cmd.set_outside = 1'b1;
               state_in        = S_DONE;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = S_DONE;
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               cmd.set_clear = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/dtpb_datapath.sv @@
// Datapath for the depth tested pixel blend block: size registers, color and
// depth stores, blend arithmetic and result registers. Depends on dtpb_pkg.
`timescale 1ns / 1ps

module dtpb_datapath import dtpb_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output stat_type                    stat,
   input  logic [OP_BITS-1:0]          req_op,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic [CHAN_BITS-1:0]        req_src_red,
   input  logic [CHAN_BITS-1:0]        req_src_green,
   input  logic [CHAN_BITS-1:0]        req_src_blue,
   input  logic [CHAN_BITS-1:0]        req_src_alpha,
   input  logic [PIX_DEPTH_BITS-1:0]   req_src_depth,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CFG_BITS-1:0]         csr_write_data,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [CHAN_BITS-1:0]        rsp_pix_red,
   output logic [CHAN_BITS-1:0]        rsp_pix_green,
   output logic [CHAN_BITS-1:0]        rsp_pix_blue,
   output logic [CHAN_BITS-1:0]        rsp_pix_alpha,
   output logic [PIX_DEPTH_BITS-1:0]   rsp_pix_depth
);

   localparam int COLOR_BITS = 4 * CHAN_BITS;
   localparam int PROD_BITS  = 2 * CHAN_BITS;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COLOR_BITS-1:0] color;
      logic [DEPTH_BITS-1:0] depth;
   } item_type;

   localparam logic [DEPTH_BITS-1:0] FAR = {DEPTH_BITS{1'b1}};

   function automatic logic [31:0] eff_size(logic [CFG_BITS-1:0] r, int maxv);
      logic [31:0] v;
      v = 32'(r);
      if (v == 32'd0) begin
         return 32'd1;
      end
      if (v > 32'(maxv)) begin
         return 32'(maxv);
      end
      return v;
   endfunction

   // exact floor(n/255) for n <= 255*255
   function automatic logic [CHAN_BITS-1:0] div255(logic [PROD_BITS-1:0] n);
      logic [PROD_BITS:0] t;
      t = (PROD_BITS+1)'(n) + (PROD_BITS+1)'(1) + (PROD_BITS+1)'(n[PROD_BITS-1:CHAN_BITS]);
      return t[PROD_BITS-1:CHAN_BITS];
   endfunction

   logic [CFG_BITS-1:0]   width_ff, width_in, height_ff, height_in;
   item_type              item_ff, item_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in, sweep_ff, sweep_in;
   logic [COLOR_BITS-1:0] rd_color_ff;
   logic [DEPTH_BITS-1:0] rd_depth_ff;
   logic [PROD_BITS-1:0]  prod_src_ff [3];
   logic [PROD_BITS-1:0]  prod_src_in [3];
   logic [PROD_BITS-1:0]  prod_dst_ff [4];
   logic [PROD_BITS-1:0]  prod_dst_in [4];
   status_type            res_status_ff, res_status_in;
   logic [COLOR_BITS-1:0] res_color_ff, res_color_in;
   logic [DEPTH_BITS-1:0] res_depth_ff, res_depth_in;
   logic                  wr_ff, wr_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic [DEPTH_BITS-1:0] rsp_depth_ff, rsp_depth_in;

   logic [COLOR_BITS-1:0] color_mem [STORE_SIZE];
   logic [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];

   logic [WIDTH_BITS-1:0]        w_eff;
   logic [HEIGHT_BITS-1:0]       h_eff;
   logic                         inside_x, inside_y;
   logic [X_BITS-1:0]            x_lo;
   logic [Y_BITS-1:0]            y_lo;
   logic [Y_BITS+WIDTH_BITS-1:0] row_base;
   logic [Y_BITS+WIDTH_BITS:0]   idx_sum;
   logic [CHAN_BITS-1:0]         inv_alpha;
   logic [CHAN_BITS-1:0]         mix_chan [3];
   logic [CHAN_BITS:0]           alpha_sum;
   logic [COLOR_BITS-1:0]        mix_color;
   logic                         nearer, farther;
   logic                         mem_we;
   logic [INDEX_BITS-1:0]        wr_addr;
   logic [COLOR_BITS-1:0]        wr_color;
   logic [DEPTH_BITS-1:0]        wr_depth;

   // size registers
   assign width_in  = (csr_write_enable && csr_index == CSR_FRAME_WIDTH) ?
                      csr_write_data : width_ff;
   assign height_in = (csr_write_enable && csr_index == CSR_FRAME_HEIGHT) ?
                      csr_write_data : height_ff;
   assign w_eff = WIDTH_BITS'(eff_size(width_ff, MAX_WIDTH));
   assign h_eff = HEIGHT_BITS'(eff_size(height_ff, MAX_HEIGHT));

   // item capture
   always_comb begin
      item_in = item_ff;
      if (cmd.load_item) begin
         item_in.op    = req_op;
         item_in.pos_x = req_pos_x;
         item_in.pos_y = req_pos_y;
         item_in.color = {req_src_alpha, req_src_blue, req_src_green, req_src_red};
         item_in.depth = DEPTH_BITS'(req_src_depth);
      end
   end

   // bounds and address
   assign inside_x = !item_ff.pos_x[COORD_BITS-1] && (32'(item_ff.pos_x) < 32'(w_eff));
   assign inside_y = !item_ff.pos_y[COORD_BITS-1] && (32'(item_ff.pos_y) < 32'(h_eff));
   assign x_lo     = item_ff.pos_x[X_BITS-1:0];
   assign y_lo     = item_ff.pos_y[Y_BITS-1:0];
   assign row_base = (Y_BITS+WIDTH_BITS)'(y_lo) * (Y_BITS+WIDTH_BITS)'(w_eff);
   assign idx_sum  = (Y_BITS+WIDTH_BITS+1)'(row_base) + (Y_BITS+WIDTH_BITS+1)'(x_lo);
   assign idx_in   = cmd.calc_index ? INDEX_BITS'(idx_sum) : idx_ff;

   assign stat.op         = item_ff.op;
   assign stat.in_frame   = inside_x && inside_y;
   assign stat.sweep_last = (sweep_ff == INDEX_BITS'(STORE_SIZE - 1));

   assign sweep_in = !cmd.sweep ? sweep_ff :
                     stat.sweep_last ? '0 : sweep_ff + INDEX_BITS'(1);

   // products
   assign inv_alpha = 8'd255 - item_ff.color[3*CHAN_BITS +: CHAN_BITS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_src_in[i] = cmd.multiply ?
                          PROD_BITS'(item_ff.color[i*CHAN_BITS +: CHAN_BITS]) *
                          PROD_BITS'(item_ff.color[3*CHAN_BITS +: CHAN_BITS]) :
                          prod_src_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         prod_dst_in[i] = cmd.multiply ?
                          PROD_BITS'(rd_color_ff[i*CHAN_BITS +: CHAN_BITS]) *
                          PROD_BITS'(inv_alpha) : prod_dst_ff[i];
      end
   end

   // blend and depth test
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mix_chan[i] = div255(prod_src_ff[i] + prod_dst_ff[i]);
      end
   end

   assign alpha_sum = (CHAN_BITS+1)'(item_ff.color[3*CHAN_BITS +: CHAN_BITS]) +
                      (CHAN_BITS+1)'(div255(prod_dst_ff[3]));
   assign mix_color = {alpha_sum[CHAN_BITS] ? {CHAN_BITS{1'b1}} : alpha_sum[CHAN_BITS-1:0],
                       mix_chan[2], mix_chan[1], mix_chan[0]};
   assign nearer    = item_ff.depth < rd_depth_ff;
   assign farther   = item_ff.depth > rd_depth_ff;

   always_comb begin
      res_status_in = res_status_ff;
      res_color_in  = res_color_ff;
      res_depth_in  = res_depth_ff;
      wr_in         = wr_ff;
      if (cmd.set_outside) begin
         res_status_in = STATUS_OUTSIDE;
         res_color_in  = '0;
         res_depth_in  = '0;
         wr_in         = 1'b0;
      end else if (cmd.set_clear) begin
         res_status_in = STATUS_CLEARED;
         res_color_in  = item_ff.color;
         res_depth_in  = FAR;
         wr_in         = 1'b0;
      end else if (cmd.mix) begin
         if (item_ff.op == OP_REPLACE) begin
            if (nearer) begin
               res_status_in = STATUS_UPDATED;
               res_color_in  = item_ff.color;
               res_depth_in  = item_ff.depth;
               wr_in         = 1'b1;
            end else begin
               res_status_in = STATUS_REJECTED;
               res_color_in  = rd_color_ff;
               res_depth_in  = rd_depth_ff;
               wr_in         = 1'b0;
            end
         end else if (farther) begin
            res_status_in = STATUS_REJECTED;
            res_color_in  = rd_color_ff;
            res_depth_in  = rd_depth_ff;
            wr_in         = 1'b0;
         end else begin
            res_status_in = STATUS_UPDATED;
            res_color_in  = (item_ff.color[3*CHAN_BITS +: CHAN_BITS] == 8'd255) ?
                            item_ff.color : mix_color;
            res_depth_in  = nearer ? item_ff.depth : rd_depth_ff;
            wr_in         = 1'b1;
         end
      end
   end

   // store write port: pixel update or sweep
   assign mem_we   = (cmd.mem_write && wr_ff) || cmd.sweep;
   assign wr_addr  = cmd.sweep ? sweep_ff : idx_ff;
   assign wr_color = !cmd.sweep ? res_color_ff : cmd.sweep_zero ? '0 : item_ff.color;
   assign wr_depth = cmd.sweep ? FAR : res_depth_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         color_mem[wr_addr] <= wr_color;
         depth_mem[wr_addr] <= wr_depth;
      end
      if (cmd.mem_read) begin
         rd_color_ff <= color_mem[idx_ff];
         rd_depth_ff <= depth_mem[idx_ff];
      end
   end

   // result register
   assign rsp_status_in = cmd.rsp_load ? res_status_ff : rsp_status_ff;
   assign rsp_color_in  = cmd.rsp_load ? res_color_ff : rsp_color_ff;
   assign rsp_depth_in  = cmd.rsp_load ? res_depth_ff : rsp_depth_ff;

   assign rsp_status    = rsp_status_ff;
   assign rsp_pix_red   = rsp_color_ff[0*CHAN_BITS +: CHAN_BITS];
   assign rsp_pix_green = rsp_color_ff[1*CHAN_BITS +: CHAN_BITS];
   assign rsp_pix_blue  = rsp_color_ff[2*CHAN_BITS +: CHAN_BITS];
   assign rsp_pix_alpha = rsp_color_ff[3*CHAN_BITS +: CHAN_BITS];
   assign rsp_pix_depth = PIX_DEPTH_BITS'(rsp_depth_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_BITS'(CFG_RESET);
         height_ff <= CFG_BITS'(CFG_RESET);
         sweep_ff  <= '0;
         wr_ff     <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         sweep_ff  <= sweep_in;
         wr_ff     <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      prod_src_ff   <= prod_src_in;
      prod_dst_ff   <= prod_dst_in;
      res_status_ff <= res_status_in;
      res_color_ff  <= res_color_in;
      res_depth_ff  <= res_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

endmodule

@@ rtl/depth_tested_pixel_blend.sv @@
// Top level of the depth tested pixel blend block: controller plus datapath.
// Depends on dtpb_pkg, dtpb_ctrl, dtpb_datapath and the assertion macro header.
//
//   port group  direction  handshake               carries
//   req_*       in         req_valid / req_stall   op, position, source color, depth
//   rsp_*       out        rsp_valid / rsp_stall   status, pixel color, stored depth
//   csr_*       in         csr_write_enable        frame width / height
//
// A replace or blend item passes the address, read, multiply, mix and write states
// from accept to result; an outside item or unused op goes from address to done;
// a clear sweeps all 262144 store entries, one per cycle, then answers. The single
// store write port takes pixel writes and the sweep; one item is in flight at a time.
// After reset the stores are swept to black and far, all entries, with req_stall high.
// Results sit in an output register, so the next item is taken while rsp_stall holds
// one; csr writes are taken in any cycle.
`timescale 1ns / 1ps
`include "depth_tested_pixel_blend_macros.svh"

module depth_tested_pixel_blend import dtpb_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OP_BITS-1:0]           req_op,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic [CHAN_BITS-1:0]         req_src_red,
   input  logic [CHAN_BITS-1:0]         req_src_green,
   input  logic [CHAN_BITS-1:0]         req_src_blue,
   input  logic [CHAN_BITS-1:0]         req_src_alpha,
   input  logic [PIX_DEPTH_BITS-1:0]    req_src_depth,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [CHAN_BITS-1:0]         rsp_pix_red,
   output logic [CHAN_BITS-1:0]         rsp_pix_green,
   output logic [CHAN_BITS-1:0]         rsp_pix_blue,
   output logic [CHAN_BITS-1:0]         rsp_pix_alpha,
   output logic [PIX_DEPTH_BITS-1:0]    rsp_pix_depth,
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CFG_BITS-1:0]          csr_write_data
);

   cmd_type  ctrl_cmd;
   stat_type dp_stat;

   dtpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (ctrl_cmd),
      .stat      (dp_stat)
   );

   dtpb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .stat             (dp_stat),
      .req_op           (req_op),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_src_red      (req_src_red),
      .req_src_green    (req_src_green),
      .req_src_blue     (req_src_blue),
      .req_src_alpha    (req_src_alpha),
      .req_src_depth    (req_src_depth),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_status),
      .rsp_pix_red      (rsp_pix_red),
      .rsp_pix_green    (rsp_pix_green),
      .rsp_pix_blue     (rsp_pix_blue),
      .rsp_pix_alpha    (rsp_pix_alpha),
      .rsp_pix_depth    (rsp_pix_depth)
   );

   `DTPB_ASSERT_NEXT(a_one_item_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   `DTPB_ASSERT_NEXT(a_result_presented, clock, reset, ctrl_cmd.rsp_load, rsp_valid)
   `DTPB_ASSERT_SAME(a_no_accept_on_write, clock, reset, ctrl_cmd.mem_write || ctrl_cmd.sweep, req_stall)

endmodule
